/* hw/rtl/rse_pkg.sv */
// Shared types, constants and helpers of the RGB Sobel edge magnitude core.
// No dependencies.
package rse_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned DimW      = 11;
  localparam int unsigned PixW      = 24;
  localparam int unsigned NumLanes  = 3;
  localparam int unsigned SqW       = 22;
  localparam int unsigned RootW     = SqW / 2;
  localparam int unsigned NumSteps  = RootW;

  localparam logic [15:0] WeightRed   = 16'd13933;
  localparam logic [15:0] WeightGreen = 16'd46871;
  localparam logic [15:0] WeightBlue  = 16'd4732;

  localparam logic [DimW-1:0] ResetWidth  = DimW'(MaxWidth);
  localparam logic [DimW-1:0] ResetHeight = DimW'(MaxHeight);
  localparam logic [7:0]      ResetMax    = 8'd255;

  typedef enum logic [1:0] {
    RegWidth  = 2'd0,
    RegHeight = 2'd1,
    RegMax    = 2'd2,
    RegNone   = 2'd3
  } reg_idx_e;

  // Request traveling from the window stage into the lane pipeline.
  typedef struct packed {
    logic       vld;
    logic       eof;
    logic [7:0] max_val;
  } req_ctl_t;

  // Clamp a dimension register to 3..top.
  function automatic logic [ColW:0] clamp_dim(input logic [DimW-1:0] v,
                                              input logic [DimW-1:0] top);
    logic [DimW-1:0] r;
    begin
      r = v;
      if (v < DimW'(3)) r = DimW'(3);
      else if (v > top) r = top;
      clamp_dim = r[ColW:0];
    end
  endfunction

endpackage

/* hw/rtl/rse_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rse_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/rse_lane.sv */
// One color lane: Sobel gradients and a pipelined integer square root.
// Depends on rse_pkg.
module rse_lane (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [8:0][7:0]           pix_i,
  output logic [rse_pkg::RootW-1:0] mag_o
);
  import rse_pkg::*;

  logic signed [11:0] gx, gy;
  logic [10:0] ux, uy;
  logic [10:0] ux_q, uy_q;
  logic [SqW-1:0] sq_q;

  // Pipelined trial-square root, one result bit per stage.
  logic [SqW-1:0]   rem_q  [NumSteps-1];
  logic [RootW-1:0] root_q [NumSteps];

  always_comb begin
    gx = (12'(pix_i[6]) + {3'b0, pix_i[7], 1'b0} + 12'(pix_i[8]))
       - (12'(pix_i[0]) + {3'b0, pix_i[1], 1'b0} + 12'(pix_i[2]));
    gy = (12'(pix_i[2]) + {3'b0, pix_i[5], 1'b0} + 12'(pix_i[8]))
       - (12'(pix_i[0]) + {3'b0, pix_i[3], 1'b0} + 12'(pix_i[6]));
    ux = gx[11] ? 11'(-gx) : gx[10:0];
    uy = gy[11] ? 11'(-gy) : gy[10:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux_q <= ux;
      uy_q <= uy;
      sq_q <= SqW'(ux_q) * SqW'(ux_q) + SqW'(uy_q) * SqW'(uy_q);
    end
  end

  for (genvar s = 0; s < NumSteps; s++) begin : g_step
    logic [SqW-1:0]   rem_in;
    logic [RootW-1:0] root_in;
    logic [SqW-1:0]   trial;
    logic [RootW-1:0] cand;
    logic [RootW-1:0] root_d;
    if (s == 0) begin : g_first
      assign rem_in  = sq_q;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end
    always_comb begin
      cand  = root_in | RootW'(1 << (NumSteps - 1 - s));
      trial = SqW'(cand) * SqW'(cand);
      if (rem_in >= trial) root_d = cand;
      else root_d = root_in;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) root_q[s] <= root_d;
    end
    if (s < NumSteps - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) rem_q[s] <= rem_in;
      end
    end
  end

  assign mag_o = root_q[NumSteps-1];

endmodule

/* hw/rtl/rgb_sobel_edge_magnitude_core.sv */
// Top level of the RGB Sobel edge magnitude core: config port, line buffers,
// window, three color lanes and the weighting merge. Uses rse_pkg, rse_ram,
// rse_lane.
//
//   channel | signals                         | accepted when
//   input   | in_valid_i/in_ready_o, rgb      | in_valid_i && in_ready_o
//   output  | out_valid_o/out_ready_i, result | out_valid_o && out_ready_i
//   config  | APB psel/penable/pwrite         | psel && penable && pwrite
//
// One pixel per clock when the output is drained; each pixel passes the line
// buffer read, two gradient stages, an 11-stage square root, the weighting
// multiply and the output register before its result is valid. The whole
// pipeline advances together and stalls when its final register holds an
// untaken result. Reset clears counters, valid bits, the config registers and
// the window; line buffers and the data registers are not cleared.
module rgb_sobel_edge_magnitude_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  edge_value_o,
  output logic        end_of_frame_o
);
  import rse_pkg::*;

  localparam int unsigned Lat = NumSteps + 4;

  logic [DimW-1:0] width_q, height_q;
  logic [7:0]      max_q;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            cfg_wr, adv, in_acc;
  reg_idx_e        widx;
  logic [ColW:0]   w_eff;
  logic [RowW:0]   h_eff;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      2'd0: widx = RegWidth;
      2'd1: widx = RegHeight;
      2'd2: widx = RegMax;
      default: widx = RegNone;
    endcase
  end

  always_comb begin
    unique case (widx)
      RegWidth:  prdata = 32'(width_q);
      RegHeight: prdata = 32'(height_q);
      RegMax:    prdata = 32'(max_q);
      default:   prdata = '0;
    endcase
  end

  assign w_eff = clamp_dim(width_q, DimW'(MaxWidth));
  assign h_eff = clamp_dim(height_q, DimW'(MaxHeight));

  // Whole pipeline moves when the output register is empty or being taken.
  assign adv    = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;
  assign in_acc = in_valid_i && adv;

  // Stage 1: request pixel, read both line buffers at the current column.
  logic [PixW-1:0] pix_q, lb1_rd, lb2_rd;
  logic            s1_vld_q, s1_emit_q, s1_eof_q;
  logic [ColW-1:0] s1_col_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if ({1'b0, col_q} == w_eff - 1'b1) begin
        col_d = '0;
        if ({1'b0, row_q} == h_eff - 1'b1) row_d = '0;
        else row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
    if (cfg_wr && widx != RegNone) begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= ResetWidth;
      height_q  <= ResetHeight;
      max_q     <= ResetMax;
      col_q     <= '0;
      row_q     <= '0;
      s1_vld_q  <= 1'b0;
    end else begin
      if (cfg_wr && widx == RegWidth)  width_q  <= pwdata[DimW-1:0];
      if (cfg_wr && widx == RegHeight) height_q <= pwdata[DimW-1:0];
      if (cfg_wr && widx == RegMax)    max_q    <= pwdata[7:0];
      col_q <= col_d;
      row_q <= row_d;
      if (adv) s1_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q     <= {red_i, green_i, blue_i};
      s1_col_q  <= col_q;
      s1_emit_q <= (col_q >= ColW'(2)) && (row_q >= RowW'(2));
      s1_eof_q  <= ({1'b0, col_q} == w_eff - 1'b1) && ({1'b0, row_q} == h_eff - 1'b1);
    end
  end

  rse_ram #(.Width(PixW), .Depth(MaxWidth)) u_lb_one (
    .clk_i, .we_i(s1_vld_q && adv), .waddr_i(s1_col_q), .wdata_i(pix_q),
    .re_i(in_acc), .raddr_i(col_q), .rdata_o(lb1_rd)
  );
  rse_ram #(.Width(PixW), .Depth(MaxWidth)) u_lb_two (
    .clk_i, .we_i(s1_vld_q && adv), .waddr_i(s1_col_q), .wdata_i(lb1_rd),
    .re_i(in_acc), .raddr_i(col_q), .rdata_o(lb2_rd)
  );

  // Stage 2: window shift and capture of the 3x3 neighborhood.
  logic [PixW-1:0] win_q [6];
  logic [8:0][PixW-1:0] nb;
  logic [8:0][7:0] ch_r, ch_g, ch_b;
  req_ctl_t ctl_q [Lat];

  always_comb begin
    for (int k = 0; k < 6; k++) nb[k] = win_q[k];
    nb[6] = lb2_rd;
    nb[7] = lb1_rd;
    nb[8] = pix_q;
    for (int k = 0; k < 9; k++) begin
      ch_r[k] = nb[k][23:16];
      ch_g[k] = nb[k][15:8];
      ch_b[k] = nb[k][7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) win_q[k] <= '0;
    end else if (adv && s1_vld_q) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= lb2_rd;
      win_q[4] <= lb1_rd;
      win_q[5] <= pix_q;
    end
  end

  assign ctl_q[0] = '{vld: s1_vld_q && s1_emit_q, eof: s1_eof_q, max_val: max_q};

  for (genvar i = 0; i < Lat - 1; i++) begin : g_ctl
    req_ctl_t nxt;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) nxt <= '0;
      else if (adv) nxt <= ctl_q[i];
    end
    assign ctl_q[i+1] = nxt;
  end

  logic [RootW-1:0] mag_r, mag_g, mag_b;
  rse_lane u_lane_r (.clk_i, .en_i(adv), .pix_i(ch_r), .mag_o(mag_r));
  rse_lane u_lane_g (.clk_i, .en_i(adv), .pix_i(ch_g), .mag_o(mag_g));
  rse_lane u_lane_b (.clk_i, .en_i(adv), .pix_i(ch_b), .mag_o(mag_b));

  // Merge: weighted products, then sum, saturation and clamp.
  logic [27:0] pr_q, pg_q, pb_q;
  logic [29:0] sum;
  logic [13:0] val;
  logic [7:0]  sat, res;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_q <= 28'(mag_r) * 28'(WeightRed);
      pg_q <= 28'(mag_g) * 28'(WeightGreen);
      pb_q <= 28'(mag_b) * 28'(WeightBlue);
    end
  end

  always_comb begin
    sum = 30'(pr_q) + 30'(pg_q) + 30'(pb_q);
    val = sum[29:16];
    sat = (val > 14'd255) ? 8'd255 : val[7:0];
    res = (sat > ctl_q[Lat-1].max_val) ? ctl_q[Lat-1].max_val : sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (adv) out_valid_o <= ctl_q[Lat-1].vld;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      edge_value_o   <= res;
      end_of_frame_o <= ctl_q[Lat-1].eof;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(edge_value_o))
    else $error("result changed while stalled");
  a_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, col_q} < w_eff || $past(cfg_wr))
    else $error("column out of range");
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> edge_value_o <= $past(ctl_q[Lat-1].max_val))
    else $error("clamp violated");

endmodule
